// ===== design/md5sh_pkg.sv =====
// ----------------------------------------------------------------------------
// md5sh_pkg
// Shared types, round constants and step functions of the md5 stream hasher.
// ----------------------------------------------------------------------------
package md5sh_pkg;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PAD,
		S_LEN,
		S_INIT,
		S_STEP,
		S_FIN,
		S_DIGEST
	} state_t;

	// what follows the compression that is running
	typedef enum logic [1:0] {
		NX_IDLE,
		NX_PAD,
		NX_LEN,
		NX_DIGEST
	} next_blk_t;

	typedef struct packed {
		logic       load_byte;
		logic       pad;
		logic       len;
		logic       init;
		logic       step;
		logic [5:0] step_idx;
		logic [5:0] km_idx;
		logic       finish;
		logic       capture;
	} dp_cmd_t;

	typedef struct packed {
		logic [5:0] pos;
		logic       out_busy;
	} dp_stat_t;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;
	localparam logic [5:0] LAST_POS = 6'd63;
	localparam logic [1:0] LAST_IDX = 2'd3;

	localparam logic [31:0] MD5_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam logic [4:0] MD5_SHIFT [16] = '{
		5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
	};

	// message word used by a step
	function automatic logic [3:0] msg_index(input logic [5:0] i);
		logic [3:0] n;
		n = i[3:0];
		case (i[5:4])
			2'd0:    return n;
			2'd1:    return 4'(5 * n + 1);
			2'd2:    return 4'(3 * n + 5);
			default: return 4'(7 * n);
		endcase
	endfunction

	function automatic logic [31:0] round_fn(input logic [1:0] rnd,
		input logic [31:0] b, input logic [31:0] c, input logic [31:0] d);
		case (rnd)
			2'd0:    return d ^ (b & (c ^ d));
			2'd1:    return c ^ (d & (b ^ c));
			2'd2:    return b ^ c ^ d;
			default: return c ^ (b | ~d);
		endcase
	endfunction

	function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
		logic [63:0] t;
		t = {x, x} << s;
		return t[63:32];
	endfunction

endpackage

// ===== design/md5sh_ctrl.sv =====
// ----------------------------------------------------------------------------
// md5sh_ctrl
// Sequencer: byte intake, padding, 64-step compression runs, digest hand-off.
// ----------------------------------------------------------------------------
module md5sh_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_present,
	input  logic               in_eom,
	output logic               in_ready,
	input  md5sh_pkg::dp_stat_t stat,
	output md5sh_pkg::dp_cmd_t  cmd
);
	import md5sh_pkg::*;

	state_t    state_q, state_d;
	next_blk_t nx_q, nx_d;
	logic [5:0] idx_q, idx_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			nx_q    <= NX_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			nx_q    <= nx_d;
			idx_q   <= idx_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		nx_d     = nx_q;
		idx_d    = idx_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.step_idx = idx_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_byte = in_present;
					// position is still the one before this byte
					if (in_present && stat.pos == LAST_POS) begin
						state_d = S_INIT;
						nx_d    = in_eom ? NX_PAD : NX_IDLE;
					end else if (in_eom) begin
						state_d = S_PAD;
					end
				end
			end
			S_PAD: begin
				cmd.pad = 1'b1;
				nx_d    = (stat.pos >= LEN_POS) ? NX_LEN : NX_DIGEST;
				state_d = S_INIT;
			end
			S_LEN: begin
				cmd.len = 1'b1;
				nx_d    = NX_DIGEST;
				state_d = S_INIT;
			end
			S_INIT: begin
				cmd.init   = 1'b1;
				cmd.km_idx = '0;
				idx_d      = '0;
				state_d    = S_STEP;
			end
			S_STEP: begin
				cmd.step   = 1'b1;
				cmd.km_idx = idx_q + 6'd1;
				idx_d      = idx_q + 6'd1;
				if (idx_q == LAST_POS) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				unique case (nx_q)
					NX_IDLE:   state_d = S_IDLE;
					NX_PAD:    state_d = S_PAD;
					NX_LEN:    state_d = S_LEN;
					NX_DIGEST: state_d = S_DIGEST;
					default:   state_d = S_IDLE;
				endcase
			end
			S_DIGEST: begin
				if (!stat.out_busy) begin
					cmd.capture = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== design/md5sh_dp.sv =====
// ----------------------------------------------------------------------------
// md5sh_dp
// Datapath: block buffer, byte count, chaining and working words, digest out.
// ----------------------------------------------------------------------------
module md5sh_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          byte_in,
	input  md5sh_pkg::dp_cmd_t  cmd,
	output md5sh_pkg::dp_stat_t stat,
	output logic [31:0]         out_word,
	output logic [1:0]          out_index,
	output logic                out_last,
	output logic                out_valid,
	input  logic                out_ready
);
	import md5sh_pkg::*;

	logic [3:0][7:0] blk_q [16];
	logic [3:0][7:0] blk_d [16];
	logic [63:0] cnt_q;
	logic [5:0]  pos;
	logic [63:0] len_bits;
	logic        len_wr;
	logic [31:0] chain_q [4];
	logic [31:0] wa_q, wb_q, wc_q, wd_q;
	logic [31:0] km_q;
	logic [31:0] t_sum;
	logic [31:0] dig_q [4];
	logic        out_valid_q;
	logic [1:0]  out_idx_q;

	assign pos      = cnt_q[5:0];
	assign len_bits = {cnt_q[60:0], 3'b000};
	assign len_wr   = cmd.len || (cmd.pad && pos < LEN_POS);

	always_comb begin
		blk_d = blk_q;
		for (int w = 0; w < 16; w++) begin
			for (int l = 0; l < 4; l++) begin
				if (cmd.load_byte && 6'(4 * w + l) == pos) begin
					blk_d[w][l] = byte_in;
				end
				if (cmd.pad) begin
					if (6'(4 * w + l) == pos) begin
						blk_d[w][l] = PAD_BYTE;
					end else if (6'(4 * w + l) > pos) begin
						blk_d[w][l] = 8'h00;
					end
				end
				if (cmd.len) begin
					blk_d[w][l] = 8'h00;
				end
			end
		end
		// bit length, low word first
		if (len_wr) begin
			blk_d[14] = len_bits[31:0];
			blk_d[15] = len_bits[63:32];
		end
	end

	always_ff @(posedge clk) begin
		blk_q <= blk_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			chain_q <= '{IV_A, IV_B, IV_C, IV_D};
		end else begin
			if (cmd.load_byte) begin
				cnt_q <= cnt_q + 64'd1;
			end
			if (cmd.finish) begin
				chain_q[0] <= chain_q[0] + wa_q;
				chain_q[1] <= chain_q[1] + wb_q;
				chain_q[2] <= chain_q[2] + wc_q;
				chain_q[3] <= chain_q[3] + wd_q;
			end
			if (cmd.capture) begin
				cnt_q   <= '0;
				chain_q <= '{IV_A, IV_B, IV_C, IV_D};
			end
		end
	end

	assign t_sum = wa_q + round_fn(cmd.step_idx[5:4], wb_q, wc_q, wd_q) + km_q;

	// constant plus message word is fetched one step ahead
	always_ff @(posedge clk) begin
		if (cmd.init || cmd.step) begin
			km_q <= MD5_K[cmd.km_idx] + blk_q[msg_index(cmd.km_idx)];
		end
		if (cmd.init) begin
			wa_q <= chain_q[0];
			wb_q <= chain_q[1];
			wc_q <= chain_q[2];
			wd_q <= chain_q[3];
		end else if (cmd.step) begin
			wa_q <= wd_q;
			wd_q <= wc_q;
			wc_q <= wb_q;
			wb_q <= wb_q + rotl32(t_sum, MD5_SHIFT[{cmd.step_idx[5:4], cmd.step_idx[1:0]}]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			dig_q <= chain_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_idx_q   <= '0;
		end else if (cmd.capture) begin
			out_valid_q <= 1'b1;
			out_idx_q   <= '0;
		end else if (out_valid_q && out_ready) begin
			out_idx_q <= out_idx_q + 2'd1;
			if (out_idx_q == LAST_IDX) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_word      = dig_q[out_idx_q];
	assign out_index     = out_idx_q;
	assign out_last      = (out_idx_q == LAST_IDX);
	assign out_valid     = out_valid_q;
	assign stat.pos      = pos;
	assign stat.out_busy = out_valid_q;

endmodule

// ===== design/md5_stream_hasher_unit.sv =====
// ----------------------------------------------------------------------------
// md5_stream_hasher_unit
// MD5 digest over a byte stream, four digest words per message.
// ----------------------------------------------------------------------------
// input beats: s_tdata carries one message byte, valid when s_tuser is high;
// s_tlast ends the message after the beat's byte (an empty last beat is fine).
// output beats: four digest words A..D, m_tuser gives the word number and
// m_tlast marks word D; digest bytes are each word's bytes, low byte first.
// the input takes one byte per cycle. every 64th byte runs a compression
// (one load, 64 rounds on one shared round adder, one chaining add) before
// the next beat is taken. a final beat adds a padding step and a compression,
// plus a length step and another compression when eight or fewer bytes are
// left in the block, then the digest moves into the output register once it
// is free; the words then leave at one per cycle while the receiver is ready.
// reset loads the initial vector, clears the byte count and empties the
// output. while the receiver stalls the digest words hold; the next message
// can still be taken in, but its digest waits until all four words are gone.
// ----------------------------------------------------------------------------
module md5_stream_hasher_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  s_tdata,   // data_byte[7:0]
	input  logic        s_tuser,   // byte_present
	input  logic        s_tlast,   // end_of_message
	input  logic        s_tvalid,
	output logic        s_tready,
	output logic [31:0] m_tdata,   // digest_word[31:0]
	output logic [1:0]  m_tuser,   // word_index[1:0]
	output logic        m_tlast,   // last_word
	output logic        m_tvalid,
	input  logic        m_tready
);
	import md5sh_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	md5sh_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_present (s_tuser),
		.in_eom     (s_tlast),
		.in_ready   (s_tready),
		.stat       (stat),
		.cmd        (cmd)
	);

	md5sh_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_in   (s_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.out_word  (m_tdata),
		.out_index (m_tuser),
		.out_last  (m_tlast),
		.out_valid (m_tvalid),
		.out_ready (m_tready)
	);

	// a new digest never overwrites words still waiting
	a_capture_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> !m_tvalid)
		else $error("digest captured while output busy");

	a_capture_first: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> m_tvalid && m_tuser == 2'd0)
		else $error("digest output did not start at word A");

	a_word_advance: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tuser == $past(m_tuser) + 2'd1)
		else $error("digest words out of order");

	// no beat is taken while padding, a length block or a compression is running
	a_no_intake_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step || cmd.init || cmd.finish || cmd.pad || cmd.len) |-> !s_tready)
		else $error("input taken during block processing");

endmodule

// ===== dv/tb_md5_stream_hasher_unit.sv =====
// ----------------------------------------------------------------------------
// tb_md5_stream_hasher_unit
// Self-checking bench for the md5 stream hasher: byte messages go in through
// the stream input, and every digest word that comes out is compared with a
// software md5 kept beside the block. Both sides idle at random. One long
// receiver stall fills the block up and stalls its input.
// ----------------------------------------------------------------------------

class md5_digest_tracker;

	typedef struct packed {
		logic [31:0] word;
		logic [1:0]  index;
		logic        last;
	} digest_beat_t;

	logic [31:0]  round_k [64];
	logic [4:0]   rot_amt [16];
	logic [31:0]  chain [4];
	logic [31:0]  blk [16];
	logic [63:0]  byte_count;
	digest_beat_t pending_words [$];
	int           fails;

	function new();
		round_k = '{
			32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
			32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
			32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
			32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
			32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
			32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
			32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
			32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
			32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
			32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
			32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
			32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
			32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
			32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
			32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
			32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
		};
		rot_amt = '{
			5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
			5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
		};
		foreach (blk[i]) blk[i] = '0;
		fails = 0;
		restart_chain();
	endfunction

	function void restart_chain();
		chain[0] = 32'h67452301;
		chain[1] = 32'hefcdab89;
		chain[2] = 32'h98badcfe;
		chain[3] = 32'h10325476;
		byte_count = '0;
	endfunction

	function void place_byte(int pos, logic [7:0] v);
		blk[pos >> 2][(pos & 3) * 8 +: 8] = v;
	endfunction

	function void compress_block();
		logic [31:0] a, b, c, d, f, t, r;
		int g;
		int s;
		a = chain[0];
		b = chain[1];
		c = chain[2];
		d = chain[3];
		for (int i = 0; i < 64; i++) begin
			case (i >> 4)
				0: begin
					f = d ^ (b & (c ^ d));
					g = i;
				end
				1: begin
					f = c ^ (d & (b ^ c));
					g = (5 * i + 1) % 16;
				end
				2: begin
					f = b ^ c ^ d;
					g = (3 * i + 5) % 16;
				end
				default: begin
					f = c ^ (b | ~d);
					g = (7 * i) % 16;
				end
			endcase
			t = a + f + round_k[i] + blk[g];
			s = rot_amt[((i >> 4) << 2) | (i & 3)];
			r = (t << s) | (t >> (32 - s));
			a = d;
			d = c;
			c = b;
			b = b + r;
		end
		chain[0] += a;
		chain[1] += b;
		chain[2] += c;
		chain[3] += d;
	endfunction

	// one accepted input beat; a final beat queues the four digest words
	function void note_beat(logic [7:0] data, logic present, logic eom);
		int pos;
		logic [63:0] bits;
		digest_beat_t e;
		if (present) begin
			pos = int'(byte_count[5:0]);
			place_byte(pos, data);
			byte_count += 1;
			if (pos == 63) compress_block();
		end
		if (!eom) return;
		pos = int'(byte_count[5:0]);
		place_byte(pos, 8'h80);
		for (int i = pos + 1; i < 64; i++) place_byte(i, 8'h00);
		// no room left for the length: run an extra block
		if (pos >= 56) begin
			compress_block();
			foreach (blk[i]) blk[i] = '0;
		end
		bits = byte_count << 3;
		blk[14] = bits[31:0];
		blk[15] = bits[63:32];
		compress_block();
		for (int i = 0; i < 4; i++) begin
			e.word  = chain[i];
			e.index = 2'(i);
			e.last  = (i == 3);
			pending_words.push_back(e);
		end
		restart_chain();
	endfunction

	function void check_word(logic [31:0] word, logic [1:0] index, logic last);
		digest_beat_t e;
		if (pending_words.size() == 0) begin
			$error("digest word %h with no digest pending", word);
			fails++;
			return;
		end
		e = pending_words.pop_front();
		if (word !== e.word) begin
			$error("digest_word: expected %h, got %h", e.word, word);
			fails++;
		end
		if (index !== e.index) begin
			$error("word_index: expected %0d, got %0d", e.index, index);
			fails++;
		end
		if (last !== e.last) begin
			$error("last_word: expected %0d, got %0d", e.last, last);
			fails++;
		end
	endfunction

endclass

module tb_md5_stream_hasher_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;

	logic        clk;
	logic        arst_n;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        s_tlast;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        m_tvalid;
	logic        m_tready;

	md5_digest_tracker digests = new();

	bit sender_fast;
	bit hold_request;
	int msg_items;
	int idle_cycles;

	md5_stream_hasher_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// valid stays high across back-to-back beats, dropped only for a gap
	task automatic send_beat(logic [7:0] data, logic present, logic eom);
		int gap;
		gap = sender_fast ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata  <= data;
		s_tuser  <= present;
		s_tlast  <= eom;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		digests.note_beat(data, present, eom);
	endtask

	// stray empty beat without end mark, ignored by the block
	task automatic send_noise();
		send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
	endtask

	// a message of len bytes; the end mark rides on the last byte or on an
	// empty beat of its own
	task automatic send_message(int len, bit mark_on_byte);
		sender_fast = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0) send_noise();
			send_beat(8'($urandom_range(0, 255)), 1'b1,
				mark_on_byte && (i == len - 1));
			msg_items++;
		end
		if (!mark_on_byte || len == 0) begin
			send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
			msg_items++;
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (digests.pending_words.size() != 0) @(posedge clk);
	endtask

	// receiver: random stalls, fast stretches, and one long hold-off
	initial begin
		int gap;
		bit fast;
		bit hold_done;
		int words;
		hold_done = 0;
		words = 0;
		fast = 0;
		m_tready = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (words % 8 == 0) fast = ($urandom_range(0, 3) == 0);
			gap = fast ? 0 : $urandom_range(0, 9);
			if (hold_request && !hold_done) begin
				gap = HOLD_CYCLES;
				hold_done = 1;
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			digests.check_word(m_tdata, m_tuser, m_tlast);
			words++;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("md5_stream_hasher_unit verification failed");
				$finish;
			end
		end
	end

	initial begin
		idle_cycles = 0;
		hold_request = 0;
		sender_fast = 0;
		msg_items = 0;
		arst_n   = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		s_tlast  = 1'b0;
		s_tvalid = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty message: a lone empty final beat
		send_beat(8'hff, 1'b0, 1'b1);
		// "abc" with the end mark on its last byte
		send_beat(8'h61, 1'b1, 1'b0);
		send_beat(8'h62, 1'b1, 1'b0);
		send_beat(8'h63, 1'b1, 1'b1);
		// byte extremes mixed with ignored empty beats, closed by an empty end
		send_beat(8'hff, 1'b0, 1'b0);
		send_beat(8'h00, 1'b1, 1'b0);
		send_beat(8'hff, 1'b1, 1'b0);
		send_beat(8'h00, 1'b0, 1'b0);
		send_beat(8'hff, 1'b1, 1'b0);
		send_beat(8'h00, 1'b1, 1'b0);
		send_beat(8'h5a, 1'b0, 1'b1);
		// single-byte messages at both extremes
		send_beat(8'hff, 1'b1, 1'b1);
		send_beat(8'h00, 1'b1, 1'b1);
		wait_drained();

		// length spills into an extra block, then a full block ended by its
		// last byte
		send_message(56, 1'($urandom_range(0, 1)));
		send_message(64, 1'b1);
		wait_drained();

		hold_request = 1;
		msg_items = 0;
		while (msg_items < 25) begin
			if ($urandom_range(0, 1))
				send_message($urandom_range(0, 6), 1'($urandom_range(0, 1)));
			else
				send_message($urandom_range(7, 20), 1'($urandom_range(0, 1)));
		end
		wait_drained();
		repeat (200) @(posedge clk);

		if (digests.fails == 0 && digests.pending_words.size() == 0) begin
			$display("md5_stream_hasher_unit verification clean");
		end else begin
			$display("md5_stream_hasher_unit verification failed");
		end
		$finish;
	end

endmodule

// ===== md5_stream_hasher_unit.f =====
design/md5sh_pkg.sv
design/md5sh_ctrl.sv
design/md5sh_dp.sv
design/md5_stream_hasher_unit.sv
dv/tb_md5_stream_hasher_unit.sv
